// ===== hw/rtl/sdq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared constants for the sleep delta queue: opcodes, field widths and
// reset values.
// ----------------------------------------------------------------------------
package sdq_pkg;

	localparam int MAX_THREADS_DEF = 16;

	localparam int OPCODE_W = 2;
	localparam int TID_W    = 4;
	localparam int TICKS_W  = 32;
	localparam int SLICE_W  = 8;

	localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_SLEEP  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_SWITCH = 2'd2;

	localparam logic KIND_WOKEN  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd2;

endpackage

// ===== hw/rtl/sleep_delta_queue_with_quantum.sv =====
// ----------------------------------------------------------------------------
// sleep_delta_queue_with_quantum
// Delta-list sleep timer for thread ids with a time-slice counter.
// List entries (gap, link) live in one synchronous single-port-write memory.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  in       | in_valid / in_ready       | opcode, thread_id, sleep_ticks
//  out      | out_valid / out_ready     | kind, woken_thread, switch_request,
//           |                           | rejected, last
//  cfg      | cfg_wr_en (no wait)       | cfg_wr_data (time slice length)
//
// One request at a time; in_ready is high only between requests.
// Tick: decrements the head gap, then emits one result per woken thread and
// the closing status; an empty list gives the status alone.
// Sleep: reads one list entry per entry examined, then writes up to three
// entries. Switch, rejected and unused opcodes give the status alone.
// Each result waits for out_ready.
// Reset is asynchronous; the memory needs no clearing pass.
// ----------------------------------------------------------------------------
module sleep_delta_queue_with_quantum #(
	parameter int MAX_THREADS = sdq_pkg::MAX_THREADS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_wr_en,
	input  logic [sdq_pkg::SLICE_W-1:0]    cfg_wr_data,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sdq_pkg::OPCODE_W-1:0]   opcode,
	input  logic [sdq_pkg::TID_W-1:0]      thread_id,
	input  logic [sdq_pkg::TICKS_W-1:0]    sleep_ticks,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           kind,
	output logic [sdq_pkg::TID_W-1:0]      woken_thread,
	output logic                           switch_request,
	output logic                           rejected,
	output logic                           last
);

	localparam int IDX_W = $clog2(MAX_THREADS);

	typedef struct packed {
		logic [sdq_pkg::TICKS_W-1:0] gap;
		logic                        has_next;
		logic [IDX_W-1:0]            link;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_WALK,
		S_INS_T,
		S_INS_CUR,
		S_INS_PREV,
		S_STATUS
	} state_t;

	entry_t                       mem [MAX_THREADS];
	entry_t                       rd_q;

	state_t                       state_q;
	logic [IDX_W-1:0]             head_q;
	logic                         nonempty_q;
	logic [sdq_pkg::SLICE_W-1:0]  slice_q;
	logic [sdq_pkg::SLICE_W-1:0]  tsl_q;
	logic [MAX_THREADS-1:0]       sleeping_q;
	logic [sdq_pkg::TICKS_W-1:0]  rem_q;
	logic [IDX_W-1:0]             cur_q;
	logic [IDX_W-1:0]             prev_q;
	logic [sdq_pkg::TICKS_W-1:0]  prev_gap_q;
	logic                         have_prev_q;
	logic                         cur_valid_q;
	logic [IDX_W-1:0]             tid_q;
	logic                         first_q;
	logic                         sw_q;
	logic                         rej_q;

	logic                         out_valid_q;
	logic                         kind_q;
	logic [sdq_pkg::TID_W-1:0]    woken_q;
	logic                         sw_out_q;
	logic                         rej_out_q;
	logic                         last_q;

	logic                         accept;
	logic                         emit_ok;
	logic                         emit;
	logic [IDX_W-1:0]             tid_idx;
	logic                         tid_ok;
	logic                         sleep_go;
	logic                         tick_dec;
	logic [sdq_pkg::TICKS_W-1:0]  tick_gap;
	logic                         walk_go;
	logic [sdq_pkg::SLICE_W-1:0]  slice_dec;
	logic                         slice_exp;

	logic                         rd_en;
	logic [IDX_W-1:0]             rd_addr;
	logic                         wr_en;
	logic [IDX_W-1:0]             wr_addr;
	entry_t                       wr_data;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign emit_ok  = !out_valid_q || out_ready;
	assign emit     = emit_ok && ((state_q == S_STATUS) ||
	                              ((state_q == S_TICK) && (tick_gap == '0)));

	assign tid_idx  = IDX_W'(thread_id);
	assign tid_ok   = (32'(thread_id) < MAX_THREADS) && !sleeping_q[tid_idx];
	assign sleep_go = (opcode == sdq_pkg::OP_SLEEP) && (sleep_ticks != '0) && tid_ok;

	assign tick_dec = first_q && (rd_q.gap != '0);
	assign tick_gap = tick_dec ? rd_q.gap - 32'd1 : rd_q.gap;
	assign walk_go  = (rd_q.gap <= rem_q);

	assign slice_dec = (slice_q != '0) ? slice_q - 8'd1 : '0;
	assign slice_exp = (slice_dec == '0);

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign woken_thread   = woken_q;
	assign switch_request = sw_out_q;
	assign rejected       = rej_out_q;
	assign last           = last_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head_q;
		wr_en   = 1'b0;
		wr_addr = head_q;
		wr_data = rd_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && nonempty_q &&
				    ((opcode == sdq_pkg::OP_TICK) || sleep_go)) begin
					rd_en   = 1'b1;
					rd_addr = head_q;
				end
			end
			S_TICK: begin
				if (tick_dec) begin
					wr_en        = 1'b1;
					wr_addr      = head_q;
					wr_data      = rd_q;
					wr_data.gap  = tick_gap;
				end
				if (tick_gap == '0 && emit_ok && rd_q.has_next) begin
					rd_en   = 1'b1;
					rd_addr = rd_q.link;
				end
			end
			S_WALK: begin
				if (walk_go && rd_q.has_next) begin
					rd_en   = 1'b1;
					rd_addr = rd_q.link;
				end
			end
			S_INS_T: begin
				wr_en            = 1'b1;
				wr_addr          = tid_q;
				wr_data.gap      = rem_q;
				wr_data.has_next = cur_valid_q;
				wr_data.link     = cur_q;
			end
			S_INS_CUR: begin
				wr_en       = 1'b1;
				wr_addr     = cur_q;
				wr_data     = rd_q;
				wr_data.gap = rd_q.gap - rem_q;
			end
			S_INS_PREV: begin
				wr_en            = 1'b1;
				wr_addr          = prev_q;
				wr_data.gap      = prev_gap_q;
				wr_data.has_next = 1'b1;
				wr_data.link     = tid_q;
			end
			S_STATUS: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			nonempty_q  <= 1'b0;
			slice_q     <= sdq_pkg::SLICE_RESET;
			tsl_q       <= sdq_pkg::SLICE_RESET;
			sleeping_q  <= '0;
			out_valid_q <= 1'b0;
			first_q     <= 1'b0;
			sw_q        <= 1'b0;
			rej_q       <= 1'b0;
			have_prev_q <= 1'b0;
			cur_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tsl_q <= cfg_wr_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						have_prev_q <= 1'b0;
						cur_valid_q <= 1'b0;
						first_q     <= 1'b1;
						tid_q       <= tid_idx;
						rem_q       <= sleep_ticks;
						cur_q       <= head_q;
						rej_q       <= (opcode == sdq_pkg::OP_SLEEP) &&
						               (sleep_ticks != '0) && !tid_ok;
						case (opcode)
							sdq_pkg::OP_TICK: begin
								if (nonempty_q) begin
									sw_q    <= 1'b0;
									state_q <= S_TICK;
								end else begin
									// advance the slice
									slice_q <= slice_exp ? tsl_q : slice_dec;
									sw_q    <= slice_exp;
									state_q <= S_STATUS;
								end
							end
							sdq_pkg::OP_SLEEP: begin
								sw_q <= 1'b0;
								if (sleep_go && nonempty_q) begin
									state_q <= S_WALK;
								end else if (sleep_go) begin
									state_q <= S_INS_T;
								end else begin
									state_q <= S_STATUS;
								end
							end
							sdq_pkg::OP_SWITCH: begin
								sw_q    <= 1'b0;
								slice_q <= tsl_q;
								state_q <= S_STATUS;
							end
							default: begin
								sw_q    <= 1'b0;
								state_q <= S_STATUS;
							end
						endcase
					end
				end
				S_TICK: begin
					if (tick_gap != '0) begin
						slice_q <= slice_exp ? tsl_q : slice_dec;
						sw_q    <= slice_exp;
						state_q <= S_STATUS;
					end else if (emit_ok) begin
						kind_q               <= sdq_pkg::KIND_WOKEN;
						woken_q              <= sdq_pkg::TID_W'(head_q);
						sw_out_q             <= 1'b0;
						rej_out_q            <= 1'b0;
						last_q               <= 1'b0;
						sleeping_q[head_q]   <= 1'b0;
						first_q              <= 1'b0;
						if (rd_q.has_next) begin
							head_q <= rd_q.link;
						end else begin
							nonempty_q <= 1'b0;
							slice_q    <= slice_exp ? tsl_q : slice_dec;
							sw_q       <= slice_exp;
							state_q    <= S_STATUS;
						end
					end
				end
				S_WALK: begin
					if (walk_go) begin
						rem_q       <= rem_q - rd_q.gap;
						have_prev_q <= 1'b1;
						prev_q      <= cur_q;
						prev_gap_q  <= rd_q.gap;
						if (rd_q.has_next) begin
							cur_q <= rd_q.link;
						end else begin
							cur_valid_q <= 1'b0;
							state_q     <= S_INS_T;
						end
					end else begin
						cur_valid_q <= 1'b1;
						state_q     <= S_INS_T;
					end
				end
				S_INS_T: begin
					if (!have_prev_q) begin
						head_q     <= tid_q;
						nonempty_q <= 1'b1;
					end
					sleeping_q[tid_q] <= 1'b1;
					slice_q           <= tsl_q;
					sw_q              <= 1'b1;
					if (cur_valid_q) begin
						state_q <= S_INS_CUR;
					end else if (have_prev_q) begin
						state_q <= S_INS_PREV;
					end else begin
						state_q <= S_STATUS;
					end
				end
				S_INS_CUR: begin
					state_q <= have_prev_q ? S_INS_PREV : S_STATUS;
				end
				S_INS_PREV: begin
					state_q <= S_STATUS;
				end
				S_STATUS: begin
					if (emit_ok) begin
						kind_q      <= sdq_pkg::KIND_STATUS;
						woken_q     <= '0;
						sw_out_q    <= sw_q;
						rej_out_q   <= rej_q;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sleep delta queue. Requests go in through the
// valid/ready input channel. A timer model inside the bench predicts every
// wakeup and closing status. Results are checked in order, field by field.
// The run covers directed corner cases first, then random traffic under
// several quantum settings, with random stalls on both channels but for the last, calm run.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sdq_pkg::*;

	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 600000;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic                kind;
		logic [TID_W-1:0]    woken;
		logic                sw;
		logic                rej;
		logic                last;
	} timer_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [SLICE_W-1:0]  cfg_wr_data;
	logic                in_valid;
	logic                in_ready;
	logic [OPCODE_W-1:0] opcode;
	logic [TID_W-1:0]    thread_id;
	logic [TICKS_W-1:0]  sleep_ticks;
	logic                out_valid;
	logic                out_ready;
	logic                kind;
	logic [TID_W-1:0]    woken_thread;
	logic                switch_request;
	logic                rejected;
	logic                last;

	// timer model state
	logic [TICKS_W-1:0]  wake_gap  [MAX_THREADS_DEF];
	logic [TID_W-1:0]    wake_link [MAX_THREADS_DEF];
	logic                wake_more [MAX_THREADS_DEF];
	logic                asleep    [MAX_THREADS_DEF];
	logic [TID_W-1:0]    list_head;
	logic                list_live;
	logic [SLICE_W-1:0]  slice_count;
	logic [SLICE_W-1:0]  quantum;

	timer_result_t       due_events[$];

	bit                  calm;
	int                  fail_count;
	int                  sent_count;
	int                  checked_count;
	int                  wakeup_count;
	int                  refused_count;
	int                  cycle_count;

	sleep_delta_queue_with_quantum dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.thread_id      (thread_id),
		.sleep_ticks    (sleep_ticks),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.woken_thread   (woken_thread),
		.switch_request (switch_request),
		.rejected       (rejected),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic timer_result_t make_result(input logic k, input logic [TID_W-1:0] id,
			input logic sw, input logic rej, input logic lst);
		timer_result_t r;
		r.kind  = k;
		r.woken = id;
		r.sw    = sw;
		r.rej   = rej;
		r.last  = lst;
		return r;
	endfunction

	task automatic predict_request(input logic [OPCODE_W-1:0] op, input logic [TID_W-1:0] tid,
			input logic [TICKS_W-1:0] ticks);
		logic [TICKS_W-1:0] remaining;
		logic [TID_W-1:0]   cur;
		logic [TID_W-1:0]   prev;
		logic [TID_W-1:0]   h;
		logic               cur_ok;
		logic               have_prev;
		logic               sw;
		logic               rej;
		int                 guard;
		int                 woken;
		sw = 1'b0;
		rej = 1'b0;
		woken = 0;
		case (op)
			OP_TICK: begin
				if (list_live && wake_gap[list_head] != '0)
					wake_gap[list_head] = wake_gap[list_head] - 1'b1;
				while (list_live && wake_gap[list_head] == '0 && woken < MAX_THREADS_DEF) begin
					h = list_head;
					due_events.push_back(make_result(KIND_WOKEN, h, 1'b0, 1'b0, 1'b0));
					woken++;
					asleep[h] = 1'b0;
					if (wake_more[h])
						list_head = wake_link[h];
					else
						list_live = 1'b0;
					wake_more[h] = 1'b0;
				end
				if (slice_count != '0)
					slice_count = slice_count - 1'b1;
				if (slice_count == '0) begin
					sw = 1'b1;
					slice_count = quantum;
				end
			end
			OP_SLEEP: begin
				if (ticks != '0) begin
					if (asleep[tid]) begin
						rej = 1'b1;
					end else begin
						remaining = ticks;
						have_prev = 1'b0;
						prev = '0;
						cur = list_head;
						cur_ok = list_live;
						guard = 0;
						while (cur_ok && guard < MAX_THREADS_DEF && wake_gap[cur] <= remaining) begin
							remaining = remaining - wake_gap[cur];
							have_prev = 1'b1;
							prev = cur;
							cur_ok = wake_more[cur];
							cur = wake_link[cur];
							guard++;
						end
						wake_gap[tid] = remaining;
						wake_more[tid] = cur_ok;
						wake_link[tid] = cur;
						if (cur_ok)
							wake_gap[cur] = wake_gap[cur] - remaining;
						if (have_prev) begin
							wake_link[prev] = tid;
							wake_more[prev] = 1'b1;
						end else begin
							list_head = tid;
							list_live = 1'b1;
						end
						asleep[tid] = 1'b1;
						sw = 1'b1;
						slice_count = quantum;
					end
				end
			end
			OP_SWITCH: begin
				slice_count = quantum;
			end
			default: begin
			end
		endcase
		due_events.push_back(make_result(KIND_STATUS, '0, sw, rej, 1'b1));
	endtask

	// present one request; returns at the edge where it is accepted
	task automatic send_request(input logic [OPCODE_W-1:0] op, input logic [TID_W-1:0] tid,
			input logic [TICKS_W-1:0] ticks);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		thread_id <= tid;
		sleep_ticks <= ticks;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		predict_request(op, tid, ticks);
		sent_count++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_events.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_quantum(input logic [SLICE_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		quantum = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_traffic(input int count);
		int                 pick;
		logic [TID_W-1:0]   tid;
		logic [TICKS_W-1:0] ticks;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			tid = TID_W'($urandom_range(0, 13));
			if ($urandom_range(0, 7) == 0)
				ticks = $urandom_range(7, 40);
			else
				ticks = $urandom_range(1, 6);
			if (pick < 40) begin
				send_request(OP_SLEEP, tid, ticks);
			end else if (pick < 45) begin
				send_request(OP_SLEEP, 4'($urandom_range(0, 15)), '0);
			end else if (pick < 50) begin
				// long sleeps stay on the two top ids so the rest keep cycling
				send_request(OP_SLEEP, 4'($urandom_range(14, 15)), $urandom);
			end else if (pick < 88) begin
				send_request(OP_TICK, 4'($urandom_range(0, 15)), $urandom);
			end else if (pick < 95) begin
				send_request(OP_SWITCH, 4'($urandom_range(0, 15)), $urandom);
			end else begin
				send_request(OP_UNUSED, 4'($urandom_range(0, 15)), $urandom);
			end
		end
	endtask

	task automatic test_full_wakeup();
		for (int i = 0; i < MAX_THREADS_DEF; i++)
			send_request(OP_SLEEP, 4'(i), 32'd1);
		send_request(OP_TICK, '0, '0);
	endtask

	task automatic test_sleep_corners();
		send_request(OP_SLEEP, 4'd4, 32'd3);
		send_request(OP_SLEEP, 4'd4, 32'd9);
		send_request(OP_SLEEP, 4'd5, 32'd0);
		send_request(OP_SLEEP, 4'd6, 32'd1);
		send_request(OP_SWITCH, 4'd15, 32'hFFFF_FFFF);
		send_request(OP_UNUSED, 4'd10, 32'h5A5A_A5A5);
		send_request(OP_SLEEP, 4'd15, 32'hFFFF_FFFF);
		send_request(OP_TICK, '0, '0);
	endtask

	task automatic test_quantum_extremes();
		set_quantum(8'd1);
		run_traffic(70);
		set_quantum(8'd255);
		run_traffic(70);
		// zero quantum: once the slice counter is at zero, every tick asks for a switch
		set_quantum(8'd0);
		run_traffic(50);
	endtask

	task automatic test_quantum_random();
		set_quantum(8'($urandom_range(1, 254)));
		run_traffic(80);
	endtask

	task automatic test_settled_traffic();
		set_quantum(SLICE_RESET);
		calm = 1'b1;
		run_traffic(76);
	endtask

	initial begin
		int hold;
		out_ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (!calm && hold == 0 && $urandom_range(0, 5) == 0)
				hold = $urandom_range(1, 9);
			if (!calm && hold > 0) begin
				out_ready <= 1'b0;
				hold--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		timer_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (due_events.size() == 0) begin
				$error("unexpected result: kind %0d woken_thread %0d", kind, woken_thread);
				fail_count++;
			end else begin
				want = due_events.pop_front();
				checked_count++;
				if (kind === KIND_WOKEN)
					wakeup_count++;
				if (rejected === 1'b1)
					refused_count++;
				if (kind !== want.kind) begin
					$error("kind: expected %0d actual %0d", want.kind, kind);
					fail_count++;
				end
				if (woken_thread !== want.woken) begin
					$error("woken_thread: expected %0d actual %0d", want.woken, woken_thread);
					fail_count++;
				end
				if (switch_request !== want.sw) begin
					$error("switch_request: expected %0d actual %0d", want.sw, switch_request);
					fail_count++;
				end
				if (rejected !== want.rej) begin
					$error("rejected: expected %0d actual %0d", want.rej, rejected);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d actual %0d", want.last, last);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles, %0d results outstanding",
				cycle_count, due_events.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = SLICE_RESET;
		in_valid = 1'b0;
		opcode = OP_TICK;
		thread_id = '0;
		sleep_ticks = '0;
		calm = 1'b0;
		fail_count = 0;
		sent_count = 0;
		checked_count = 0;
		wakeup_count = 0;
		refused_count = 0;
		cycle_count = 0;
		for (int i = 0; i < MAX_THREADS_DEF; i++) begin
			wake_gap[i] = '0;
			wake_link[i] = '0;
			wake_more[i] = 1'b0;
			asleep[i] = 1'b0;
		end
		list_head = '0;
		list_live = 1'b0;
		quantum = SLICE_RESET;
		slice_count = SLICE_RESET;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_full_wakeup();
		test_sleep_corners();
		test_quantum_extremes();
		test_quantum_random();
		test_settled_traffic();

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("tb: %0d requests, %0d results checked, %0d thread wakeups, %0d refused sleeps",
			sent_count, checked_count, wakeup_count, refused_count);
		$display("tb: quantum at reset, 1, 255, 0 and one random value; %0d cycles",
			cycle_count);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
